// ===== hw/rtl/fp16_rti_pkg.sv =====
// ----------------------------------------------------------------------------
// fp16_rti_pkg: shared constants and types for binary16 round-to-integral
// Field layout, rounding mode codes and the handoff struct between stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fp16_rti_pkg;

  localparam int unsigned DataWidth = 16;
  localparam int unsigned ExpWidth  = 5;
  localparam int unsigned FracWidth = 10;

  localparam logic [ExpWidth-1:0]  ExpMax  = 5'd31;
  localparam logic [ExpWidth-1:0]  ExpBias = 5'd15;
  localparam logic [DataWidth-1:0] SignBit = 16'h8000;
  localparam logic [DataWidth-1:0] OneBits = 16'h3C00;

  typedef enum logic [1:0] {
    OpCeil  = 2'd0,
    OpFloor = 2'd1,
    OpNear  = 2'd2,
    OpTrunc = 2'd3
  } round_op_e;

  // Registered operand beat handed to the rounding datapath
  typedef struct packed {
    logic                 valid;
    logic [DataWidth-1:0] bits;
    round_op_e            op;
  } operand_beat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fp16_rti_round.sv =====
// ----------------------------------------------------------------------------
// fp16_rti_round: combinational round-to-integral datapath
// Clears fraction bits below the binary point and steps toward the mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fp16_rti_round (
  input  wire logic [fp16_rti_pkg::DataWidth-1:0] x_i,
  input  wire fp16_rti_pkg::round_op_e            op_i,
  output logic      [fp16_rti_pkg::DataWidth-1:0] y_o
);

  logic        sign;
  logic [4:0]  bexp;
  logic [9:0]  frac;
  logic [3:0]  fb;
  logic [11:0] unit;
  logic [11:0] mask;
  logic [11:0] m;
  logic [11:0] rem;
  logic [11:0] ip;
  logic [11:0] ip_up;
  logic        up;
  logic [4:0]  exp_out;
  logic [9:0]  frac_out;
  logic [15:0] small_res;

  assign sign = x_i[15];
  assign bexp = x_i[14:10];
  assign frac = x_i[9:0];

  // Work out the clear mask for magnitudes of one and above
  assign fb    = 4'd10 - 4'(bexp - fp16_rti_pkg::ExpBias);
  assign unit  = 12'd1 << fb;
  assign mask  = unit - 12'd1;
  assign m     = {2'b01, frac};
  assign rem   = m & mask;
  assign ip    = m & ~mask;

  // Decide the step toward the mode
  always_comb begin
    up = 1'b0;
    if (rem != 12'd0) begin
      case (op_i)
        fp16_rti_pkg::OpCeil:  up = ~sign;
        fp16_rti_pkg::OpFloor: up = sign;
        fp16_rti_pkg::OpNear:  up = (rem > (unit >> 1)) ||
                                    ((rem == (unit >> 1)) && ((ip & unit) != 12'd0));
        default:               up = 1'b0;
      endcase
    end
  end

  // Add the step and renormalize on carry out
  always_comb begin
    ip_up = up ? (ip + unit) : ip;
    if (ip_up[11]) begin
      exp_out  = bexp + 5'd1;
      frac_out = ip_up[10:1];
    end else begin
      exp_out  = bexp;
      frac_out = ip_up[9:0];
    end
  end

  // Resolve magnitudes below one
  always_comb begin
    case (op_i)
      fp16_rti_pkg::OpCeil:  small_res = sign ? fp16_rti_pkg::SignBit : fp16_rti_pkg::OneBits;
      fp16_rti_pkg::OpFloor: small_res = sign ? (fp16_rti_pkg::SignBit | fp16_rti_pkg::OneBits)
                                              : 16'h0000;
      fp16_rti_pkg::OpNear:  small_res = (bexp >= (fp16_rti_pkg::ExpBias - 5'd1))
                                         ? {sign, fp16_rti_pkg::OneBits[14:0]} : 16'h0000;
      default:               small_res = {sign, 15'd0};
    endcase
  end

  // Select pass-through, small or stepped result
  always_comb begin
    if (bexp == fp16_rti_pkg::ExpMax || (bexp == 5'd0 && frac == 10'd0) ||
        bexp >= (fp16_rti_pkg::ExpBias + 5'd10)) begin
      y_o = x_i;
    end else if (bexp < fp16_rti_pkg::ExpBias) begin
      y_o = small_res;
    end else begin
      y_o = {sign, exp_out, frac_out};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fp16_round_to_integral_core.sv =====
// start passes through the input register's valid bit into done_q, which drives done_o;
// the result register loads on the same edge, so the beat is held while done_o is high.
// Throughput: one operand per cycle; busy is held low, start is never refused.
// Input register and result register sit around one combinational rounding stage.
// Reset clears the valid bits of both registers; the receiver cannot stall.
// ----------------------------------------------------------------------------
// fp16_round_to_integral_core: binary16 round-to-integral, top level
// Registers the operand, rounds it, and strobes the registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fp16_round_to_integral_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] operand_bits_i,
  input  wire logic [1:0]  operation_i,
  output logic             done_o,
  output logic [15:0]      rounded_bits_o
);

  fp16_rti_pkg::operand_beat_t in_q;
  logic                        done_q;
  logic [15:0]                 res_q;
  logic [15:0]                 res_d;

  assign busy = 1'b0;

  // Capture an operand beat on every start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q.valid <= 1'b0;
      in_q.bits  <= '0;
      in_q.op    <= fp16_rti_pkg::OpCeil;
    end else begin
      in_q.valid <= start;
      if (start) begin
        in_q.bits <= operand_bits_i;
        in_q.op   <= fp16_rti_pkg::round_op_e'(operation_i);
      end
    end
  end

  fp16_rti_round u_round (
    .x_i  (in_q.bits),
    .op_i (in_q.op),
    .y_o  (res_d)
  );

  // Hold the result beat for one strobe cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_q.valid) begin
      res_q <= res_d;
    end
  end

  assign done_o         = done_q;
  assign rounded_bits_o = res_q;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for fp16_round_to_integral_core
// Drives binary16 operands with every rounding mode in bursts, predicts each
// integral result and checks every done_o beat in order against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import fp16_rti_pkg::*;

class round_scoreboard;
  logic [15:0] pending_q[$];
  int          errors;

  // Compute the integral binary16 value for one operand and mode
  function automatic logic [15:0] round_integral(logic [15:0] x, round_op_e op);
    logic        sgn;
    logic [4:0]  bexp;
    logic [9:0]  frac;
    int unsigned fb, unit, mask, mant, rem, ip;
    logic        up;
    sgn  = x[15];
    bexp = x[14:10];
    frac = x[9:0];
    if (bexp == ExpMax) return x;
    if (bexp == 5'd0 && frac == 10'd0) return x;
    if (bexp >= 5'd25) return x;
    if (bexp < ExpBias) begin
      case (op)
        OpCeil:  return sgn ? SignBit : OneBits;
        OpFloor: return sgn ? (SignBit | OneBits) : 16'h0000;
        OpNear:  return (bexp >= 5'd14) ? ({sgn, 15'd0} | OneBits) : 16'h0000;
        default: return {sgn, 15'd0};
      endcase
    end
    fb   = 10 - (bexp - 15);
    unit = 1 << fb;
    mask = unit - 1;
    mant = 32'h400 | frac;
    rem  = mant & mask;
    ip   = mant & ~mask;
    up   = 1'b0;
    if (rem != 0) begin
      if (op == OpCeil) up = !sgn;
      else if (op == OpFloor) up = sgn;
      else if (op == OpNear)
        up = (rem > (unit >> 1)) || (rem == (unit >> 1) && (ip & unit) != 0);
    end
    if (up) ip = ip + unit;
    if (ip >= 32'h800) begin
      ip   = ip >> 1;
      bexp = bexp + 5'd1;
    end
    return {sgn, bexp, ip[9:0]};
  endfunction

  function void note_operand(logic [15:0] x, round_op_e op);
    pending_q.push_back(round_integral(x, op));
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  task check_result(logic [15:0] got);
    logic [15:0] want;
    if (pending_q.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) report($sformatf("rounded_bits got %h want %h", got, want));
  endtask
endclass

module tb;
  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] operand_bits_i;
  logic [1:0]  operation_i;
  logic        done_o;
  logic [15:0] rounded_bits_o;

  round_scoreboard sb;
  int unsigned     cycles;

  fp16_round_to_integral_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operand_bits_i (operand_bits_i),
    .operation_i    (operation_i),
    .done_o         (done_o),
    .rounded_bits_o (rounded_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check each result beat at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(rounded_bits_o);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("fp16_round_to_integral_core: mismatch");
      $finish;
    end
  end

  // Present one operand beat and hold it until accepted
  task automatic send_operand(logic [15:0] x, round_op_e op);
    start          <= 1'b1;
    operand_bits_i <= x;
    operation_i    <= op;
    do @(posedge clk_i); while (busy);
    sb.note_operand(x, op);
  endtask

  task automatic drop_start();
    start <= 1'b0;
    operand_bits_i <= 16'($urandom);
    operation_i    <= 2'($urandom);
  endtask

  // Bias toward the interesting exponent band around the binary point
  function automatic logic [15:0] pick_operand();
    logic [15:0] x;
    x = 16'($urandom);
    case ($urandom_range(0, 3))
      0: x[14:10] = 5'($urandom_range(13, 25));
      1: x[14:10] = 5'($urandom_range(15, 24));
      default: ;
    endcase
    return x;
  endfunction

  logic [15:0] directed_q[$];
  int          burst;

  initial begin
    sb = new();
    cycles = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    operand_bits_i = 16'h0000;
    operation_i = OpCeil;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zeros, NaN, infinity, subnormal, below and at one half, ties, carry
    directed_q = '{16'h0000, 16'h8000, 16'h7E01, 16'hFC00, 16'h0001, 16'h83FF,
                   16'h37FF, 16'h3800, 16'hB800, 16'h3E00, 16'h4100, 16'hC100,
                   16'h3BFF, 16'h63FF, 16'h6400, 16'hFBFF, 16'h67FF, 16'h3C01};
    foreach (directed_q[i])
      for (int op = 0; op < 4; op++) send_operand(directed_q[i], round_op_e'(op));

    // Random bursts with random gaps
    for (int n = 0; n < 1700; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++, n++)
        send_operand(pick_operand(), round_op_e'($urandom_range(0, 3)));
      if ($urandom_range(0, 2) != 0) begin
        drop_start();
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    drop_start();

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("fp16_round_to_integral_core: match");
    else
      $display("fp16_round_to_integral_core: mismatch");
    $finish;
  end
endmodule

// ===== fp16_round_to_integral_core.f =====
hw/rtl/fp16_rti_pkg.sv
hw/rtl/fp16_rti_round.sv
hw/rtl/fp16_round_to_integral_core.sv
tb/tb.sv
